/* rtl/core/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// Thermostat cycle controller package
// Shared widths, register map, codes and reset values of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  // Field widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TempW    = 16;
  localparam int unsigned HystW    = 15;
  localparam int unsigned SecW     = 16;
  localparam int unsigned ElapsedW = 14;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned KindW    = 2;

  // Configuration port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 3;

  // Register indexes
  localparam logic [IdxW-1:0] RegMode      = 3'd0;
  localparam logic [IdxW-1:0] RegSetpoint  = 3'd1;
  localparam logic [IdxW-1:0] RegHyst      = 3'd2;
  localparam logic [IdxW-1:0] RegLimitLow  = 3'd3;
  localparam logic [IdxW-1:0] RegLimitHigh = 3'd4;
  localparam logic [IdxW-1:0] RegMinCycle  = 3'd5;
  localparam logic [IdxW-1:0] RegMaxCycle  = 3'd6;

  // Operating modes
  localparam logic [ModeW-1:0] ModeOff  = 2'd0;
  localparam logic [ModeW-1:0] ModeHeat = 2'd1;
  localparam logic [ModeW-1:0] ModeCool = 2'd2;

  // Call kinds
  localparam logic [KindW-1:0] CallNone = 2'd0;
  localparam logic [KindW-1:0] CallHeat = 2'd1;
  localparam logic [KindW-1:0] CallCool = 2'd2;

  // Elapsed time handling and limit margin (2 degrees)
  localparam logic [TimeW-1:0]    ElapsedLimit = 32'd10000;
  localparam logic [ElapsedW-1:0] ElapsedClamp = 14'd600;
  localparam logic [TempW:0]      LimitMargin  = 17'sd32;

  // Register reset values
  localparam logic [ModeW-1:0]        ResetMode      = ModeOff;
  localparam logic signed [TempW-1:0] ResetSetpoint  = 16'sd320;
  localparam logic [HystW-1:0]        ResetHyst      = 15'd16;
  localparam logic signed [TempW-1:0] ResetLimitLow  = 16'sd160;
  localparam logic signed [TempW-1:0] ResetLimitHigh = 16'sd480;
  localparam logic [SecW-1:0]         ResetMinCycle  = 16'd300;
  localparam logic [SecW-1:0]         ResetMaxCycle  = 16'd3600;

  // Configuration register set
  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [TempW-1:0] setpoint;
    logic [HystW-1:0]        hysteresis;
    logic signed [TempW-1:0] limit_low;
    logic signed [TempW-1:0] limit_high;
    logic [SecW-1:0]         min_cycle_seconds;
    logic [SecW-1:0]         max_cycle_seconds;
  } tcc_cfg_t;

  // Controller state
  typedef struct packed {
    logic [TimeW-1:0] last_change_time;
    logic             last_demand;
    logic             first_call;
  } tcc_state_t;

  // State update requests from the decision logic
  typedef struct packed {
    logic load_demand;
    logic load_time;
    logic clear_first;
  } tcc_update_t;

  // One result item
  typedef struct packed {
    logic [ElapsedW-1:0] elapsed_seconds;
    logic [KindW-1:0]    call_kind;
    logic                demand;
    logic                demand_changed;
  } tcc_result_t;

endpackage

`default_nettype wire

/* rtl/core/tcc_in_if.sv */
// ----------------------------------------------------------------------------
// Thermostat input channel
// Valid/ready channel carrying one time and temperature reading.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if import tcc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [TimeW-1:0]        now_seconds;
  logic signed [TempW-1:0] temperature;
  logic                    manual_on;

  modport source (output valid, output now_seconds, output temperature,
                  output manual_on, input ready);
  modport sink   (input valid, input now_seconds, input temperature,
                  input manual_on, output ready);
endinterface

`default_nettype wire

/* rtl/core/tcc_out_if.sv */
// ----------------------------------------------------------------------------
// Thermostat result channel
// Valid/ready channel carrying one demand decision.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_out_if import tcc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ElapsedW-1:0] elapsed_seconds;
  logic [KindW-1:0]    call_kind;
  logic                demand;
  logic                demand_changed;

  modport source (output valid, output elapsed_seconds, output call_kind,
                  output demand, output demand_changed, input ready);
  modport sink   (input valid, input elapsed_seconds, input call_kind,
                  input demand, input demand_changed, output ready);
endinterface

`default_nettype wire

/* rtl/core/thermostat_cycle_controller_unit.sv */
// ----------------------------------------------------------------------------
// Thermostat cycle controller
// Bang-bang heat/cool demand with hysteresis, limits and cycle-time rules.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// in_chan   in   valid/ready             now_seconds, temperature, manual_on
// out_chan  out  valid/ready             elapsed_seconds, call_kind, demand,
//                                        demand_changed
// cfg       in   psel/penable/pwrite     paddr, pwdata -> prdata, pready
//
// One transaction is accepted per cycle while the result side is not stalled;
// its result is presented from the result register.
// The decision and the state update happen as an item leaves the input
// register, so each item sees the state left by the one before it.
// A stalled result register holds the input register; input ready drops only
// when both are full. Reset clears the state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_cycle_controller_unit import tcc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  tcc_in_if.sink                in_chan,
  tcc_out_if.source             out_chan,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  tcc_cfg_t    cfg;
  tcc_state_t  state;
  tcc_result_t res_next;
  tcc_update_t upd;

  logic                    s1_valid;
  logic [TimeW-1:0]        s1_now;
  logic signed [TempW-1:0] s1_temp;
  logic                    s1_force;
  logic                    out_valid;
  tcc_result_t             out_res;
  logic                    advance;
  logic                    in_take;

  // Configuration registers
  tcc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake control
  assign advance       = s1_valid && (!out_valid || out_chan.ready);
  assign in_chan.ready = !s1_valid || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid <= in_chan.valid;
    end
    if (in_take) begin
      s1_now   <= in_chan.now_seconds;
      s1_temp  <= in_chan.temperature;
      s1_force <= in_chan.manual_on;
    end
  end

  // Decision logic
  tcc_decide u_decide (
    .cfg         (cfg),
    .state       (state),
    .now_seconds (s1_now),
    .temperature (s1_temp),
    .manual_on   (s1_force),
    .result      (res_next),
    .update      (upd)
  );

  // Controller state, updated as an item is decided
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_change_time <= '0;
      state.last_demand      <= 1'b0;
      state.first_call       <= 1'b1;
    end else if (advance) begin
      if (upd.load_demand) begin
        state.last_demand <= res_next.demand;
      end
      if (upd.load_time) begin
        state.last_change_time <= s1_now;
      end
      if (upd.clear_first) begin
        state.first_call <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign out_chan.valid           = out_valid;
  assign out_chan.elapsed_seconds = out_res.elapsed_seconds;
  assign out_chan.call_kind       = out_res.call_kind;
  assign out_chan.demand          = out_res.demand;
  assign out_chan.demand_changed  = out_res.demand_changed;

endmodule

`default_nettype wire

/* rtl/core/tcc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Thermostat configuration registers
// APB-style register file holding mode, setpoint, band, limits and cycle times.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cfg_regs import tcc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output tcc_cfg_t              cfg
);

  logic            wr_en;
  logic [IdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // Register writes; unmapped indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= ResetMode;
      cfg.setpoint          <= ResetSetpoint;
      cfg.hysteresis        <= ResetHyst;
      cfg.limit_low         <= ResetLimitLow;
      cfg.limit_high        <= ResetLimitHigh;
      cfg.min_cycle_seconds <= ResetMinCycle;
      cfg.max_cycle_seconds <= ResetMaxCycle;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegMode:      cfg.mode              <= pwdata[ModeW-1:0];
        RegSetpoint:  cfg.setpoint          <= pwdata[TempW-1:0];
        RegHyst:      cfg.hysteresis        <= pwdata[HystW-1:0];
        RegLimitLow:  cfg.limit_low         <= pwdata[TempW-1:0];
        RegLimitHigh: cfg.limit_high        <= pwdata[TempW-1:0];
        RegMinCycle:  cfg.min_cycle_seconds <= pwdata[SecW-1:0];
        RegMaxCycle:  cfg.max_cycle_seconds <= pwdata[SecW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back multiplexer; signed fields are sign extended.
  always_comb begin
    unique case (reg_idx)
      RegMode:      prdata = {{(DataW-ModeW){1'b0}}, cfg.mode};
      RegSetpoint:  prdata = {{(DataW-TempW){cfg.setpoint[TempW-1]}}, cfg.setpoint};
      RegHyst:      prdata = {{(DataW-HystW){1'b0}}, cfg.hysteresis};
      RegLimitLow:  prdata = {{(DataW-TempW){cfg.limit_low[TempW-1]}}, cfg.limit_low};
      RegLimitHigh: prdata = {{(DataW-TempW){cfg.limit_high[TempW-1]}}, cfg.limit_high};
      RegMinCycle:  prdata = {{(DataW-SecW){1'b0}}, cfg.min_cycle_seconds};
      RegMaxCycle:  prdata = {{(DataW-SecW){1'b0}}, cfg.max_cycle_seconds};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/tcc_decide.sv */
// ----------------------------------------------------------------------------
// Thermostat demand decision
// Combinational rule chain: force, max on-time, limits and hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_decide import tcc_pkg::*; (
  input  wire tcc_cfg_t           cfg,
  input  wire tcc_state_t         state,
  input  wire logic [TimeW-1:0]   now_seconds,
  input  wire logic signed [TempW-1:0] temperature,
  input  wire logic               manual_on,
  output tcc_result_t             result,
  output tcc_update_t             update
);

  logic [TimeW-1:0]        elapsed_raw;
  logic [ElapsedW-1:0]     elapsed;
  logic signed [TempW+1:0] temp_x;
  logic signed [TempW+1:0] setpoint_x;
  logic signed [TempW+1:0] half_x;
  logic signed [TempW+1:0] low_cut;
  logic signed [TempW+1:0] high_cut;
  logic signed [TempW+1:0] thr_up;
  logic signed [TempW+1:0] thr_down;
  logic                    max_hit;
  logic                    timed_ok;
  logic [KindW-1:0]        kind;
  logic                    dem;
  logic                    clear_first;
  logic                    changed;

  // Time since the last demand change, clamped when it is implausibly large.
  assign elapsed_raw = now_seconds - state.last_change_time;
  assign elapsed     = (elapsed_raw > ElapsedLimit) ? ElapsedClamp
                                                    : elapsed_raw[ElapsedW-1:0];

  assign max_hit  = ({{(SecW-ElapsedW){1'b0}}, elapsed} >= cfg.max_cycle_seconds);
  assign timed_ok = state.first_call ||
                    ({{(SecW-ElapsedW){1'b0}}, elapsed} >= cfg.min_cycle_seconds);

  // Temperatures widened by two bits so sums with the margin and band never wrap.
  assign temp_x     = {{2{temperature[TempW-1]}}, temperature};
  assign setpoint_x = {{2{cfg.setpoint[TempW-1]}}, cfg.setpoint};
  assign half_x     = {4'b0000, cfg.hysteresis[HystW-1:1]};
  assign low_cut    = {{2{cfg.limit_low[TempW-1]}}, cfg.limit_low}
                      - {LimitMargin[TempW], LimitMargin};
  assign high_cut   = {{2{cfg.limit_high[TempW-1]}}, cfg.limit_high}
                      + {LimitMargin[TempW], LimitMargin};
  assign thr_up     = setpoint_x + half_x;
  assign thr_down   = setpoint_x - half_x;

  // Rule chain in priority order.
  always_comb begin
    kind        = CallNone;
    dem         = 1'b0;
    clear_first = 1'b0;
    if (manual_on) begin
      kind = (cfg.mode == ModeCool) ? CallCool : CallHeat;
      dem  = 1'b1;
    end else if (max_hit && state.last_demand) begin
      kind = (cfg.mode == ModeCool) ? CallCool : CallHeat;
    end else if (cfg.mode == ModeCool && temp_x < low_cut) begin
      kind = CallCool;
    end else if (cfg.mode == ModeHeat && temp_x > high_cut) begin
      kind = CallHeat;
    end else if (cfg.mode == ModeCool) begin
      if (timed_ok) begin
        kind        = CallCool;
        dem         = temp_x > (state.last_demand ? thr_down : thr_up);
        clear_first = dem;
      end
    end else if (cfg.mode == ModeHeat) begin
      kind = CallHeat;
      if (timed_ok) begin
        dem         = temp_x < (state.last_demand ? thr_up : thr_down);
        clear_first = dem;
      end else begin
        dem = state.last_demand;
      end
    end
  end

  assign changed = (kind != CallNone) && (dem != state.last_demand);

  assign result.elapsed_seconds = elapsed;
  assign result.call_kind       = kind;
  assign result.demand          = (kind != CallNone) && dem;
  assign result.demand_changed  = changed;

  assign update.load_demand = (kind != CallNone);
  assign update.load_time   = changed && !manual_on;
  assign update.clear_first = clear_first;

endmodule

`default_nettype wire

/* rtl/core/tcc_checker.sv */
// ----------------------------------------------------------------------------
// Thermostat controller port checker
// Concurrent assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_checker import tcc_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [ElapsedW-1:0] elapsed_seconds,
  input wire logic [KindW-1:0]    call_kind,
  input wire logic                demand,
  input wire logic                demand_changed
);

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Without a call no demand and no change is reported.
  a_no_call_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && call_kind == CallNone |-> !demand && !demand_changed)
    else $error("demand reported without a call");

  // Call kind is heat, cool or none.
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> call_kind == CallNone || call_kind == CallHeat ||
                  call_kind == CallCool)
    else $error("invalid call kind");

  // Elapsed time never exceeds the clamp limit.
  a_elapsed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {{(TimeW-ElapsedW){1'b0}}, elapsed_seconds} <= ElapsedLimit)
    else $error("elapsed time out of range");

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind thermostat_cycle_controller_unit tcc_checker u_tcc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .elapsed_seconds (out_chan.elapsed_seconds),
  .call_kind       (out_chan.call_kind),
  .demand          (out_chan.demand),
  .demand_changed  (out_chan.demand_changed)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat cycle controller testbench
// Drives time and temperature readings into the controller under random
// valid/ready pacing and checks every demand decision against an in-bench
// predictor of the heat/cool rules. The register set is reprogrammed between
// phases, including extreme settings, and is read back after each write.
// ----------------------------------------------------------------------------
module testbench;
  import tcc_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned IdlePercent   = 31;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseItems    = 90;

  // Mode code 3 is not named in the package; the controller treats it as off.
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0]        now_seconds;
    logic signed [TempW-1:0] temperature;
    logic                    manual_on;
  } reading_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  tcc_in_if  in_chan();
  tcc_out_if out_chan();

  thermostat_cycle_controller_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and the controller state.
  tcc_cfg_t         shadow_cfg;
  logic [TimeW-1:0] shadow_change_time;
  logic             shadow_demand;
  logic             shadow_first;

  reading_t    readings_waiting[$];
  tcc_result_t decisions_due[$];
  reading_t    seen;
  reading_t    next_reading;
  tcc_result_t want;

  logic [TimeW-1:0] stim_clock = '0;
  bit               in_taken = 1'b0;
  bit               calm = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      cycle_count = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      results_checked = 0;
  int unsigned      backpressure_cycles = 0;
  int unsigned      settings_count = 0;

  always #(HalfPeriod) clk = ~clk;

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Works out the decision for one reading and advances the predicted state.
  function automatic tcc_result_t decide_demand(reading_t rd);
    tcc_result_t      res;
    logic [TimeW-1:0] span;
    int               temp, band_half, sp, lo_cut, hi_cut, thr;
    logic [KindW-1:0] kind;
    logic             dem, changed;
    span = rd.now_seconds - shadow_change_time;
    if (span > ElapsedLimit) begin
      span = 32'(ElapsedClamp);
    end
    temp = $signed(rd.temperature);
    sp = $signed(shadow_cfg.setpoint);
    band_half = shadow_cfg.hysteresis >> 1;
    lo_cut = $signed(shadow_cfg.limit_low);
    lo_cut = lo_cut - int'(LimitMargin);
    hi_cut = $signed(shadow_cfg.limit_high);
    hi_cut = hi_cut + int'(LimitMargin);
    kind = CallNone;
    dem = 1'b0;
    changed = 1'b0;
    if (rd.manual_on) begin
      kind = (shadow_cfg.mode == ModeCool) ? CallCool : CallHeat;
      dem = 1'b1;
    end else if (span >= shadow_cfg.max_cycle_seconds && shadow_demand) begin
      kind = (shadow_cfg.mode == ModeCool) ? CallCool : CallHeat;
    end else if (shadow_cfg.mode == ModeCool && temp < lo_cut) begin
      kind = CallCool;
    end else if (shadow_cfg.mode == ModeHeat && temp > hi_cut) begin
      kind = CallHeat;
    end else if (shadow_cfg.mode == ModeCool) begin
      thr = shadow_demand ? sp - band_half : sp + band_half;
      if (shadow_first || span >= shadow_cfg.min_cycle_seconds) begin
        kind = CallCool;
        dem = temp > thr;
        if (dem) begin
          shadow_first = 1'b0;
        end
      end
    end else if (shadow_cfg.mode == ModeHeat) begin
      thr = shadow_demand ? sp + band_half : sp - band_half;
      kind = CallHeat;
      if (shadow_first || span >= shadow_cfg.min_cycle_seconds) begin
        dem = temp < thr;
        if (dem) begin
          shadow_first = 1'b0;
        end
      end else begin
        dem = shadow_demand;
      end
    end
    // A forced call changes the demand but keeps the cycle start time.
    if (kind != CallNone) begin
      changed = (dem != shadow_demand);
      shadow_demand = dem;
      if (changed && !rd.manual_on) begin
        shadow_change_time = rd.now_seconds;
      end
    end
    res.elapsed_seconds = span[ElapsedW-1:0];
    res.call_kind = kind;
    res.demand = (kind != CallNone) && dem;
    res.demand_changed = changed;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  function automatic bit sender_idles();
    return !calm && ($urandom_range(99) < IdlePercent);
  endfunction

  // Sample both channels: predict on each input transaction and check each
  // result transaction against the oldest prediction.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (in_chan.valid && in_chan.ready) begin
        seen.now_seconds = in_chan.now_seconds;
        seen.temperature = in_chan.temperature;
        seen.manual_on = in_chan.manual_on;
        decisions_due.push_back(decide_demand(seen));
        in_taken = 1'b1;
      end
      if (in_chan.valid && !in_chan.ready) begin
        backpressure_cycles++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (decisions_due.size() == 0) begin
          $error("result transaction with no reading outstanding");
          mismatch_count++;
        end else begin
          want = decisions_due.pop_front();
          check_field("elapsed_seconds", want.elapsed_seconds, out_chan.elapsed_seconds);
          check_field("call_kind", want.call_kind, out_chan.call_kind);
          check_field("demand", want.demand, out_chan.demand);
          check_field("demand_changed", want.demand_changed, out_chan.demand_changed);
          results_checked++;
        end
      end
    end
  end

  // Reading driver: presents the next pending reading once the slot is free.
  always @(negedge clk) begin
    if (rst) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (readings_waiting.size() != 0 && !sender_idles()) begin
        next_reading = readings_waiting.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.now_seconds <= next_reading.now_seconds;
        in_chan.temperature <= next_reading.temperature;
        in_chan.manual_on <= next_reading.manual_on;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_chan.ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Writes one register over the APB port, then reads it back.
  task automatic program_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] value);
    logic [DataW-1:0] mask;
    mask = '0;
    case (idx)
      RegMode: begin
        shadow_cfg.mode = value[ModeW-1:0];
        mask = 32'h3;
      end
      RegSetpoint: begin
        shadow_cfg.setpoint = value[TempW-1:0];
        mask = 32'hFFFF;
      end
      RegHyst: begin
        shadow_cfg.hysteresis = value[HystW-1:0];
        mask = 32'h7FFF;
      end
      RegLimitLow: begin
        shadow_cfg.limit_low = value[TempW-1:0];
        mask = 32'hFFFF;
      end
      RegLimitHigh: begin
        shadow_cfg.limit_high = value[TempW-1:0];
        mask = 32'hFFFF;
      end
      RegMinCycle: begin
        shadow_cfg.min_cycle_seconds = value[SecW-1:0];
        mask = 32'hFFFF;
      end
      RegMaxCycle: begin
        shadow_cfg.max_cycle_seconds = value[SecW-1:0];
        mask = 32'hFFFF;
      end
      default: begin
        mask = '0;
      end
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Back-to-back read of the same register.
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (value & mask)) begin
      $error("register %0d readback: expected %0h, got %0h", idx, value & mask,
             prdata & mask);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_all(logic [ModeW-1:0] mode_v, int sp, int hyst, int lo, int hi,
                             int minc, int maxc);
    program_reg(RegMode, DataW'(mode_v));
    program_reg(RegSetpoint, DataW'(sp));
    program_reg(RegHyst, DataW'(hyst));
    program_reg(RegLimitLow, DataW'(lo));
    program_reg(RegLimitHigh, DataW'(hi));
    program_reg(RegMinCycle, DataW'(minc));
    program_reg(RegMaxCycle, DataW'(maxc));
    settings_count++;
  endtask

  // Moderate settings where the hysteresis and cycle rules all come into play.
  task automatic program_random(logic [ModeW-1:0] mode_v);
    int sp;
    sp = int'($urandom_range(1200)) - 400;
    program_all(mode_v, sp, $urandom_range(64), sp - int'($urandom_range(400, 100)),
                sp + int'($urandom_range(400, 100)), $urandom_range(400),
                $urandom_range(4000));
  endtask

  task automatic queue_reading(logic [TimeW-1:0] now_v, int temp_v, bit forced);
    reading_t rd;
    rd.now_seconds = now_v;
    rd.temperature = TempW'(temp_v);
    rd.manual_on = forced;
    readings_waiting.push_back(rd);
  endtask

  // Random readings: time mostly creeps forward so that the cycle timers
  // expire now and then, with jumps past the clamp and some steps backwards.
  // Temperatures cluster around the setpoint and the limits.
  task automatic queue_random(int count);
    int center, spread, lo, hi, t, pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 84) begin
        stim_clock = stim_clock + $urandom_range(250);
      end else if (pick < 95) begin
        stim_clock = stim_clock + $urandom_range(60000, 9000);
      end else if (pick < 98) begin
        stim_clock = $urandom;
      end
      center = $signed(shadow_cfg.setpoint);
      spread = int'(shadow_cfg.hysteresis) + 24;
      lo = $signed(shadow_cfg.limit_low);
      hi = $signed(shadow_cfg.limit_high);
      pick = $urandom_range(99);
      if (pick < 72) begin
        t = center + int'($urandom_range(2 * spread)) - spread;
      end else if (pick < 90) begin
        t = ($urandom_range(1) ? lo : hi) + int'($urandom_range(96)) - 48;
      end else begin
        t = int'($urandom_range(65535)) - 32768;
      end
      if (t > 32767) begin
        t = 32767;
      end
      if (t < -32768) begin
        t = -32768;
      end
      queue_reading(stim_clock, t, $urandom_range(99) < 8);
    end
  endtask

  // Waits until every reading is taken and every decision has come back.
  task automatic drain();
    while (readings_waiting.size() != 0 || in_chan.valid || decisions_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.now_seconds = '0;
    in_chan.temperature = '0;
    in_chan.manual_on = 1'b0;
    out_chan.ready = 1'b0;
    shadow_cfg.mode = ResetMode;
    shadow_cfg.setpoint = ResetSetpoint;
    shadow_cfg.hysteresis = ResetHyst;
    shadow_cfg.limit_low = ResetLimitLow;
    shadow_cfg.limit_high = ResetLimitHigh;
    shadow_cfg.min_cycle_seconds = ResetMinCycle;
    shadow_cfg.max_cycle_seconds = ResetMaxCycle;
    shadow_change_time = '0;
    shadow_demand = 1'b0;
    shadow_first = 1'b1;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, mode off: idle, forced call, maximum on-time cutoff.
    queue_reading(32'd0, 320, 1'b0);
    queue_reading(32'd10, -32768, 1'b1);
    queue_reading(32'd4000, 32767, 1'b0);
    queue_reading(32'd4001, 0, 1'b0);
    drain();

    // Heating: first call, min-cycle hold, hysteresis, over-limit, clamp,
    // time running backwards, extreme time and temperatures.
    program_all(ModeHeat, ResetSetpoint, ResetHyst, ResetLimitLow, ResetLimitHigh,
                ResetMinCycle, ResetMaxCycle);
    queue_reading(32'd4100, 300, 1'b0);
    queue_reading(32'd4150, 400, 1'b0);
    queue_reading(32'd4500, 330, 1'b0);
    queue_reading(32'd4600, 32767, 1'b0);
    queue_reading(32'd4700, 100, 1'b0);
    queue_reading(32'd24700, 100, 1'b0);
    queue_reading(32'd30000, 100, 1'b0);
    queue_reading(32'd29000, 100, 1'b0);
    queue_reading(32'hFFFF_FFFF, 32767, 1'b1);
    queue_reading(32'hFFFF_FFFF, -32768, 1'b0);
    drain();

    // Cooling: under-limit, no call inside min cycle, on, forced, cutoff.
    program_reg(RegMode, DataW'(ModeCool));
    queue_reading(32'hFFFF_FFFF, -32768, 1'b0);
    queue_reading(32'd0, 400, 1'b0);
    queue_reading(32'd400, 400, 1'b0);
    queue_reading(32'd500, 330, 1'b1);
    queue_reading(32'd4100, 330, 1'b0);
    queue_reading(32'd4500, 32767, 1'b0);
    drain();

    stim_clock = 32'd5000;

    program_random(ModeHeat);
    queue_random(PhaseItems);
    drain();

    // Widest band, widest limits, no minimum cycle.
    program_all(ModeCool, 0, 32767, -32768, 32767, 0, 65535);
    queue_random(PhaseItems);
    drain();

    // Zero band, inverted limits, minimum cycle never reached, no on-time.
    program_all(ModeHeat, 32767, 0, 32767, -32768, 65535, 0);
    queue_random(PhaseItems);
    drain();

    program_random(ModeSpare);
    queue_random(PhaseItems);
    drain();

    // The receiver holds off while readings keep coming, so the block fills.
    program_random(ModeCool);
    queue_random(PhaseItems);
    @(posedge clk);
    hold_left = HoldOffCycles;
    drain();

    // A stretch with no idling on either side.
    program_random(ModeHeat);
    calm = 1'b1;
    queue_random(PhaseItems);
    drain();
    calm = 1'b0;

    program_random(ModeOff);
    queue_random(PhaseItems);
    drain();

    program_all(ModeCool, -32768, 1, 32767, -32768, 65535, 0);
    queue_random(PhaseItems);
    drain();

    program_random(ModeHeat);
    queue_random(PhaseItems);
    drain();

    program_random(ModeCool);
    queue_random(PhaseItems);
    drain();

    $display("Checked %0d decisions over %0d register settings in all modes.",
             results_checked, settings_count);
    $display("Input was held back for %0d cycles while results stalled.",
             backpressure_cycles);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
